// File: sv/spq_pkg.sv
// spq_pkg: shared types and codes for the stable priority queue with boost.
// Holds default sizes, operation codes and result status codes.
// No dependencies.
package spq_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_TAG_BITS  = 8;
  localparam int DEF_PRIO_BITS = 16;

  // Operation code of an input transaction; the fourth code is a no-op.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_PUSH  = 2'd0;
  localparam mode_t MODE_BOOST = 2'd1;
  localparam mode_t MODE_SERVE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// File: sv/stable_priority_queue_with_boost.sv
// Stable priority queue with boost: top level, sequencer around one entry memory.
// One transaction is in work at a time; the next is taken once the result is in
//   the output register. The memory moves one entry per cycle.
// Reset (rst, synchronous): queue empty, no result pending; memory contents are kept.
// Depends on spq_pkg and spq_store.
module stable_priority_queue_with_boost #(
  parameter int CAPACITY  = spq_pkg::DEF_CAPACITY,
  parameter int TAG_BITS  = spq_pkg::DEF_TAG_BITS,
  parameter int PRIO_BITS = spq_pkg::DEF_PRIO_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spq_pkg::mode_t              mode,
  input  logic [TAG_BITS-1:0]         tag,
  input  logic signed [PRIO_BITS-1:0] priority_req,
  input  logic signed [PRIO_BITS-1:0] delta,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output spq_pkg::status_t            status,
  output logic                        served_valid,
  output logic [TAG_BITS-1:0]         served_tag,
  output logic signed [PRIO_BITS-1:0] served_priority
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = TAG_BITS + PRIO_BITS;

  localparam logic signed [PRIO_BITS-1:0] PRIO_MAX = {1'b0, {(PRIO_BITS-1){1'b1}}};
  localparam logic signed [PRIO_BITS-1:0] PRIO_MIN = {1'b1, {(PRIO_BITS-1){1'b0}}};

  // Sequencer states:
  //  S_INS_START  first read of the tail (or direct write into an empty queue)
  //  S_INS        walk from the tail toward the head, moving lower entries back
  //  S_INS_HEAD   new entry lands in slot 0
  //  S_FIND       scan from the head for the tag (boost) or take the head (serve)
  //  S_SHIFT      close the gap left by a removed entry
  //  S_RESULT     hand the result to the output register
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_START,
    S_INS,
    S_INS_HEAD,
    S_FIND,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             cur;       // slot whose read data arrives this cycle
  logic                         op_boost;  // boost, else serve (used in S_FIND/S_SHIFT)
  logic [TAG_BITS-1:0]          op_tag;
  logic signed [PRIO_BITS-1:0]  op_prio;   // delta during the boost scan, else new priority

  status_t                      res_status;
  logic                         res_sv;
  logic [TAG_BITS-1:0]          res_tag;
  logic signed [PRIO_BITS-1:0]  res_prio;

  // memory port
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [ENT_W-1:0]             ram_wdata;
  logic                         rd_en;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ENT_W-1:0]             ram_rdata;

  logic [TAG_BITS-1:0]          rd_tag;
  logic signed [PRIO_BITS-1:0]  rd_prio;
  logic [CNT_W-1:0]             cur_nxt;
  logic                         more;      // a slot exists above cur
  logic [IDX_W-1:0]             cur_up;
  logic [IDX_W-1:0]             cur_dn;
  logic [IDX_W-1:0]             last_idx;
  logic                         prio_ge;
  logic                         find_hit;
  logic signed [PRIO_BITS:0]    sum_w;
  logic signed [PRIO_BITS-1:0]  sat_prio;

  spq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_tag   = ram_rdata[ENT_W-1:PRIO_BITS];
  assign rd_prio  = ram_rdata[PRIO_BITS-1:0];
  assign cur_nxt  = CNT_W'(cur) + CNT_W'(1);
  assign more     = cur_nxt < count;
  assign cur_up   = cur + IDX_W'(1);
  assign cur_dn   = cur - IDX_W'(1);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  // new entry goes behind everything of greater or equal priority
  assign prio_ge  = rd_prio >= op_prio;
  assign find_hit = op_boost ? (rd_tag == op_tag) : 1'b1;

  // boost: saturating add of the delta to the matched priority
  assign sum_w = {rd_prio[PRIO_BITS-1], rd_prio} + {op_prio[PRIO_BITS-1], op_prio};
  always_comb begin
    if (sum_w[PRIO_BITS] != sum_w[PRIO_BITS-1]) begin
      sat_prio = sum_w[PRIO_BITS] ? PRIO_MIN : PRIO_MAX;
    end else begin
      sat_prio = sum_w[PRIO_BITS-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);

  // Memory access per state. Reads run two slots ahead of the writes, always on
  // the far side of the slot being written, so no read meets a pending write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_up;
    ram_wdata = {op_tag, op_prio};
    rd_en     = 1'b0;
    ram_raddr = cur_up;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (mode == MODE_BOOST || mode == MODE_SERVE) &&
            count != '0) begin
          rd_en     = 1'b1;
          ram_raddr = '0;
        end
      end
      S_INS_START: begin
        if (count == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else begin
          rd_en     = 1'b1;
          ram_raddr = last_idx;
        end
      end
      S_INS: begin
        ram_we = 1'b1;
        if (!prio_ge) begin
          ram_wdata = ram_rdata;
          if (cur != '0) begin
            rd_en     = 1'b1;
            ram_raddr = cur_dn;
          end
        end
      end
      S_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      S_FIND: begin
        // speculative read of the next slot: the scan or the gap close needs it
        rd_en = more;
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_dn;
        ram_wdata = ram_rdata;
        rd_en     = more;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_RESULT loads the output register itself
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_tag     <= tag;
            res_status <= ST_DONE;
            res_sv     <= 1'b0;
            res_tag    <= '0;
            res_prio   <= '0;
            cur        <= '0;
            case (mode)
              MODE_PUSH: begin
                op_prio <= priority_req;
                if (count == CNT_W'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_RESULT;
                end else begin
                  state <= S_INS_START;
                end
              end
              MODE_BOOST: begin
                op_prio  <= delta;
                op_boost <= 1'b1;
                if (count == '0) begin
                  res_status <= ST_NOTFOUND;
                  state      <= S_RESULT;
                end else begin
                  state <= S_FIND;
                end
              end
              MODE_SERVE: begin
                op_boost <= 1'b0;
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESULT;
                end else begin
                  state <= S_FIND;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_INS_START: begin
          if (count == '0) begin
            count <= count + CNT_W'(1);
            state <= S_RESULT;
          end else begin
            cur   <= last_idx;
            state <= S_INS;
          end
        end
        S_INS: begin
          if (prio_ge) begin
            count <= count + CNT_W'(1);
            state <= S_RESULT;
          end else if (cur == '0) begin
            state <= S_INS_HEAD;
          end else begin
            cur <= cur_dn;
          end
        end
        S_INS_HEAD: begin
          count <= count + CNT_W'(1);
          state <= S_RESULT;
        end
        S_FIND: begin
          if (find_hit) begin
            if (op_boost) begin
              op_prio <= sat_prio;
            end else begin
              res_sv   <= 1'b1;
              res_tag  <= rd_tag;
              res_prio <= rd_prio;
            end
            if (more) begin
              cur   <= cur_up;
              state <= S_SHIFT;
            end else begin
              count <= count - CNT_W'(1);
              state <= op_boost ? S_INS_START : S_RESULT;
            end
          end else if (more) begin
            cur <= cur_up;
          end else begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESULT;
          end
        end
        S_SHIFT: begin
          if (more) begin
            cur <= cur_up;
          end else begin
            count <= count - CNT_W'(1);
            // boost goes on to place the entry again
            state <= op_boost ? S_INS_START : S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            served_valid    <= res_sv;
            served_tag      <= res_tag;
            served_priority <= res_prio;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no read of a slot in the cycle it is written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && rd_en |-> ram_waddr != ram_raddr)
    else $error("memory read and write hit the same slot");

  // an accepted transaction always occupies the sequencer for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // the fill level moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |->
      count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1))
    else $error("entry count jumped");

endmodule

// File: sv/spq_store.sv
// spq_store: entry memory of the priority queue, one write and one read port.
// Read data is registered.
// Depends on spq_pkg for default sizes.
module spq_store #(
  parameter int DEPTH = spq_pkg::DEF_CAPACITY,
  parameter int WIDTH = spq_pkg::DEF_TAG_BITS + spq_pkg::DEF_PRIO_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/stable_priority_queue_with_boost_test.sv
`timescale 1ns / 100ps
// Self-checking bench for stable_priority_queue_with_boost: directed table, then random ops.
// Depends on spq_pkg and the queue RTL; holds its own queue image to predict every result.
module stable_priority_queue_with_boost_test;
  import spq_pkg::*;

  localparam int CAP    = DEF_CAPACITY;
  localparam int TAG_W  = DEF_TAG_BITS;
  localparam int PRIO_W = DEF_PRIO_BITS;

  // Fourth op code: the block ignores it but still answers with a done status.
  localparam mode_t MODE_NOP = 2'd3;

  localparam logic signed [PRIO_W-1:0] PMAX = {1'b0, {(PRIO_W-1){1'b1}}};
  localparam logic signed [PRIO_W-1:0] PMIN = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam int PMAX_I = (1 << (PRIO_W - 1)) - 1;
  localparam int PMIN_I = -(1 << (PRIO_W - 1));

  localparam int RANDOM_OPS = 900;
  // Drain this long after the last result; longer than the worst boost takes.
  localparam int DRAIN_CYCLES = 4 * CAP + 16;

  // One result transaction as the block presents it.
  typedef struct packed {
    status_t                    status;
    logic                       served_valid;
    logic [TAG_W-1:0]           served_tag;
    logic signed [PRIO_W-1:0]   served_priority;
  } outcome_t;

  // One directed row; reps > 1 repeats a push with tag and priority stepped by one.
  typedef struct packed {
    mode_t                      op;
    logic [TAG_W-1:0]           tag;
    logic signed [PRIO_W-1:0]   prio;
    logic signed [PRIO_W-1:0]   delta;
    logic [4:0]                 reps;
    logic                       typed;
    outcome_t                   want;
  } plan_row_t;

  localparam outcome_t OUT_DONE     = '{ST_DONE,     1'b0, '0, '0};
  localparam outcome_t OUT_EMPTY    = '{ST_EMPTY,    1'b0, '0, '0};
  localparam outcome_t OUT_NOTFOUND = '{ST_NOTFOUND, 1'b0, '0, '0};
  localparam outcome_t OUT_FULL     = '{ST_FULL,     1'b0, '0, '0};

  // Rows with typed = 0 take their expectation from the predictor.
  localparam int PLAN_ROWS = 21;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{MODE_SERVE, 8'h00, 16'sh0000, 16'sh0000, 5'd1,  1'b1, OUT_EMPTY},    // serve, empty
    '{MODE_BOOST, 8'h12, 16'sh0000, 16'sh0001, 5'd1,  1'b1, OUT_NOTFOUND}, // boost, empty
    '{MODE_NOP,   8'hFF, 16'sh7FFF, 16'sh8000, 5'd1,  1'b1, OUT_DONE},     // unused op
    '{MODE_PUSH,  8'hFF, 16'sh7FFF, 16'sh0000, 5'd1,  1'b1, OUT_DONE},
    '{MODE_PUSH,  8'h00, 16'sh8000, 16'sh0000, 5'd1,  1'b1, OUT_DONE},
    '{MODE_PUSH,  8'h55, 16'sh0000, 16'sh0000, 5'd1,  1'b1, OUT_DONE},
    '{MODE_PUSH,  8'hAA, 16'sh0000, 16'sh0000, 5'd1,  1'b1, OUT_DONE},     // tie with 0x55
    '{MODE_BOOST, 8'hFF, 16'sh0000, 16'sh7FFF, 5'd1,  1'b1, OUT_DONE},     // clamps high
    '{MODE_BOOST, 8'h00, 16'sh0000, 16'sh8000, 5'd1,  1'b1, OUT_DONE},     // clamps low
    '{MODE_BOOST, 8'h12, 16'sh0000, 16'sh0001, 5'd1,  1'b1, OUT_NOTFOUND}, // no such tag
    '{MODE_BOOST, 8'h55, 16'sh0000, 16'sh0000, 5'd1,  1'b0, OUT_DONE},     // goes behind 0xAA
    '{MODE_SERVE, 8'h00, 16'sh0000, 16'sh0000, 5'd1,  1'b1,
      '{ST_DONE, 1'b1, 8'hFF, 16'sh7FFF}},
    '{MODE_SERVE, 8'h00, 16'sh0000, 16'sh0000, 5'd1,  1'b0, OUT_DONE},
    '{MODE_PUSH,  8'h10, 16'shFFFB, 16'sh0000, 5'd14, 1'b0, OUT_DONE},     // fill up
    '{MODE_PUSH,  8'h77, 16'sh0001, 16'sh0000, 5'd1,  1'b1, OUT_FULL},
    '{MODE_BOOST, 8'h00, 16'sh0000, 16'sh0001, 5'd1,  1'b0, OUT_DONE},     // boost while full
    '{MODE_BOOST, 8'h15, 16'sh0000, 16'shFFFD, 5'd1,  1'b0, OUT_DONE},
    '{MODE_SERVE, 8'h00, 16'sh0000, 16'sh0000, 5'd1,  1'b0, OUT_DONE},
    '{MODE_PUSH,  8'h00, 16'sh7FFF, 16'sh0000, 5'd1,  1'b0, OUT_DONE},     // duplicate tag
    '{MODE_BOOST, 8'h00, 16'sh0000, 16'sh0001, 5'd1,  1'b0, OUT_DONE},     // first match only
    '{MODE_SERVE, 8'h00, 16'sh0000, 16'sh0000, 5'd1,  1'b0, OUT_DONE}
  };

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  mode_t                      mode;
  logic [TAG_W-1:0]           tag;
  logic signed [PRIO_W-1:0]   priority_req;
  logic signed [PRIO_W-1:0]   delta;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  status_t                    status;
  logic                       served_valid;
  logic [TAG_W-1:0]           served_tag;
  logic signed [PRIO_W-1:0]   served_priority;

  // Sorted image of the queue: slot 0 is the head.
  logic [TAG_W-1:0]           held_tag  [CAP];
  logic signed [PRIO_W-1:0]   held_prio [CAP];
  int                         held_count;

  outcome_t                   pending_outcomes [$];
  int                         mismatches = 0;
  bit                         steady = 1'b0;   // no idling on either side while set

  stable_priority_queue_with_boost #(
    .CAPACITY  (CAP),
    .TAG_BITS  (TAG_W),
    .PRIO_BITS (PRIO_W)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .tag             (tag),
    .priority_req    (priority_req),
    .delta           (delta),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .served_valid    (served_valid),
    .served_tag      (served_tag),
    .served_priority (served_priority)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Queue image upkeep
  // --------------------------------------------------------------------------

  // Insert behind every entry of greater or equal priority; keeps ties in arrival order.
  function automatic void place_entry(logic [TAG_W-1:0] t, logic signed [PRIO_W-1:0] p);
    int pos;
    pos = 0;
    while (pos < held_count && held_prio[pos] >= p)
      pos++;
    for (int i = held_count; i > pos; i--) begin
      held_tag[i]  = held_tag[i-1];
      held_prio[i] = held_prio[i-1];
    end
    held_tag[pos]  = t;
    held_prio[pos] = p;
    held_count++;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_tag[i]  = held_tag[i+1];
      held_prio[i] = held_prio[i+1];
    end
    held_count--;
  endfunction

  // Applies one accepted op to the image and returns the result it must produce.
  function automatic outcome_t apply_queue_op(mode_t op, logic [TAG_W-1:0] t,
                                              logic signed [PRIO_W-1:0] p,
                                              logic signed [PRIO_W-1:0] d);
    outcome_t res;
    int idx;
    int sum;
    res = OUT_DONE;
    case (op)
      MODE_PUSH: begin
        if (held_count >= CAP)
          res.status = ST_FULL;
        else
          place_entry(t, p);
      end
      MODE_BOOST: begin
        idx = 0;
        while (idx < held_count && held_tag[idx] != t)
          idx++;
        if (idx >= held_count) begin
          res.status = ST_NOTFOUND;
        end else begin
          // saturating add, then pull out and reinsert behind its equals
          sum = int'(held_prio[idx]) + int'(d);
          if (sum > PMAX_I)
            sum = PMAX_I;
          else if (sum < PMIN_I)
            sum = PMIN_I;
          drop_entry(idx);
          place_entry(t, PRIO_W'(sum));
        end
      end
      MODE_SERVE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.served_valid    = 1'b1;
          res.served_tag      = held_tag[0];
          res.served_priority = held_prio[0];
          drop_entry(0);
        end
      end
      default: ;  // unused op: nothing changes
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random field pickers
  // --------------------------------------------------------------------------

  // Mostly a small pool so boosts hit and ties happen; sometimes any tag.
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 99) < 75)
      return TAG_W'($urandom_range(0, 11));
    return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
  endfunction

  // Small values give ties, extremes exercise the clamp.
  function automatic logic signed [PRIO_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      return PRIO_W'(int'($urandom_range(0, 8)) - 4);
    else if (sel < 70)
      return PRIO_W'($urandom);
    else if (sel < 78)
      return PMAX;
    else if (sel < 85)
      return PMIN;
    else if (sel < 93)
      return PMAX - PRIO_W'($urandom_range(0, 3));
    return PMIN + PRIO_W'($urandom_range(0, 3));
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the handshake at the rising edge
  // --------------------------------------------------------------------------

  task automatic send_op(mode_t op, logic [TAG_W-1:0] t, logic signed [PRIO_W-1:0] p,
                         logic signed [PRIO_W-1:0] d, logic typed, outcome_t want);
    outcome_t predicted;
    // random idle cycles ahead of the transaction
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    mode         = op;
    tag          = t;
    priority_req = p;
    delta        = d;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // accepted at this edge: update the image and queue the expected result
    predicted = apply_queue_op(op, t, p, d);
    pending_outcomes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, compare every accepted result in order
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(negedge clk)
    out_stall = !steady && ($urandom_range(0, 99) < 25);

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d tag %h prio %0d",
                                  status, served_tag, served_priority));
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (served_valid !== want.served_valid)
          report_mismatch($sformatf("served_valid %b, expected %b",
                                    served_valid, want.served_valid));
        if (served_tag !== want.served_tag)
          report_mismatch($sformatf("served_tag %h, expected %h",
                                    served_tag, want.served_tag));
        if (served_priority !== want.served_priority)
          report_mismatch($sformatf("served_priority %0d, expected %0d",
                                    served_priority, want.served_priority));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int n;
    int sel;
    int push_pct;
    int serve_pct;
    mode_t op;
    logic [TAG_W-1:0] t;

    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_PUSH;
    tag          = '0;
    priority_req = '0;
    delta        = '0;
    held_count   = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: empty cases, extremes, ties, clamp both ways, full queue.
    for (int r = 0; r < PLAN_ROWS; r++)
      for (int k = 0; k < int'(PLAN[r].reps); k++)
        send_op(PLAN[r].op, TAG_W'(PLAN[r].tag + k), PRIO_W'(PLAN[r].prio + k),
                PLAN[r].delta, PLAN[r].typed, PLAN[r].want);

    // Random: phases of 100 alternate filling, balanced and draining so the queue
    // swings between empty and full; one stretch runs without idling.
    for (n = 0; n < RANDOM_OPS; n++) begin
      steady = (n >= 300 && n < 450);
      case ((n / 100) % 3)
        0:       begin push_pct = 55; serve_pct = 15; end
        1:       begin push_pct = 35; serve_pct = 30; end
        default: begin push_pct = 20; serve_pct = 50; end
      endcase
      sel = $urandom_range(0, 99);
      if (sel < push_pct)
        op = MODE_PUSH;
      else if (sel < push_pct + serve_pct)
        op = MODE_SERVE;
      else if (sel < 95)
        op = MODE_BOOST;
      else
        op = MODE_NOP;
      // boosts mostly aim at a tag that is actually held
      if (op == MODE_BOOST && held_count > 0 && $urandom_range(0, 99) < 80)
        t = held_tag[$urandom_range(0, held_count - 1)];
      else
        t = pick_tag();
      send_op(op, t, pick_level(), pick_level(), 1'b0, OUT_DONE);
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    while (pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("stable_priority_queue_with_boost verification clean");
    else
      $display("stable_priority_queue_with_boost verification failed");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("stable_priority_queue_with_boost verification failed");
    $finish;
  end

endmodule
